### design/csa_pkg.sv
// Shared constants, codes and control structs of the chunk slot allocator.
`timescale 1ns / 1ps

package csa_pkg;

   localparam int GRID_SIDE_DEF   = 32;
   localparam int GRID_HEIGHT_DEF = 16;
   localparam int SLOT_COUNT_DEF  = 1024;

   localparam int CELL_X_W  = 5;
   localparam int CELL_Y_W  = 4;
   localparam int CELL_Z_W  = 5;
   localparam int SLOT_ID_W = 10;
   localparam int STATUS_W  = 2;

   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [REQ_TUSER_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2,
      OP_TAKE  = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_SLOT    = 2'd1,
      STAT_EMPTY_CELL = 2'd2
   } status_type;

   typedef struct packed {
      logic read;
      logic write;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      logic read;
      logic pop;
      logic push;
      logic clear;
   } stack_ctl_type;

endpackage

### design/csa_cell_map.sv
// Cell map memory: coordinate wrap, cell index and a RAM with a registered read.
`timescale 1ns / 1ps

module csa_cell_map
   import csa_pkg::*;
#(
   parameter int GRID_SIDE   = GRID_SIDE_DEF,
   parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
   parameter int ID_W        = 10,
   localparam int CELL_TOTAL = GRID_SIDE * GRID_SIDE * GRID_HEIGHT,
   localparam int CELL_W     = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1,
   localparam int ENTRY_W    = ID_W + 1
) (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [CELL_X_W-1:0] cell_x,
   input  logic [CELL_Y_W-1:0] cell_y,
   input  logic [CELL_Z_W-1:0] cell_z,
   input  logic [CELL_W-1:0]  clear_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   output logic [ENTRY_W-1:0] rd_data
);

   localparam int CX_W = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
   localparam int CY_W = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

   logic [CX_W-1:0]    side_wrap [2**CELL_X_W];
   logic [CY_W-1:0]    height_wrap [2**CELL_Y_W];
   logic [CELL_W-1:0]  cell_idx;
   logic [CELL_W-1:0]  idx_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ENTRY_W-1:0] mem [CELL_TOTAL];

   for (genvar i = 0; i < 2**CELL_X_W; i++) begin : g_side_wrap
      assign side_wrap[i] = CX_W'(i % GRID_SIDE);
   end

   for (genvar i = 0; i < 2**CELL_Y_W; i++) begin : g_height_wrap
      assign height_wrap[i] = CY_W'(i % GRID_HEIGHT);
   end

   // x-major, then z, then y
   assign cell_idx = (CELL_W'(side_wrap[cell_x]) * CELL_W'(GRID_SIDE)
                      + CELL_W'(side_wrap[cell_z])) * CELL_W'(GRID_HEIGHT)
                     + CELL_W'(height_wrap[cell_y]);

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         mem[clear_addr] <= '0;
      end else if (ctl.write) begin
         mem[idx_ff] <= wr_data;
      end
      if (ctl.read) begin
         idx_ff     <= cell_idx;
         rd_data_ff <= mem[cell_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/csa_free_stack.sv
// Free slot stack: LIFO memory with its fill count and top-of-stack read.
`timescale 1ns / 1ps

module csa_free_stack
   import csa_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   localparam int ID_W      = $clog2(SLOT_COUNT),
   localparam int CNT_W     = $clog2(SLOT_COUNT + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  stack_ctl_type   ctl,
   input  logic [ID_W-1:0] clear_addr,
   input  logic [ID_W-1:0] push_data,
   output logic [ID_W-1:0] top_data,
   output logic            empty
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] count_dec;
   logic [ID_W-1:0]  top_addr;
   logic [ID_W-1:0]  push_addr;
   logic [ID_W-1:0]  top_ff;
   logic             full;
   logic [ID_W-1:0]  mem [SLOT_COUNT];

   assign count_dec = count_ff - CNT_W'(1);
   assign top_addr  = count_dec[ID_W-1:0];
   assign push_addr = count_ff[ID_W-1:0];
   assign empty     = (count_ff == '0);
   // a push onto a full stack is dropped
   assign full      = (count_ff == CNT_W'(SLOT_COUNT));

   always_comb begin
      count_in = count_ff;
      if (ctl.pop && !empty) begin
         count_in = count_dec;
      end else if (ctl.push && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(SLOT_COUNT);
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         mem[clear_addr] <= clear_addr;
      end else if (ctl.push && !full) begin
         mem[push_addr] <= push_data;
      end
      if (ctl.read) begin
         top_ff <= mem[top_addr];
      end
   end

   assign top_data = top_ff;

endmodule

### design/chunk_slot_allocator.sv
// Top level of the chunk slot allocator: request control, dirty range and response register.
`timescale 1ns / 1ps

// Hands out slot ids from a LIFO free list and records them in a 3-D cell map.
// In the accept cycle a request reads the cell map and the stack top; in S_EXEC
// it modifies and writes both memories back and loads the response
// register. The response register waits for rsp_tready while the next request
// is accepted; a request finishes only once that register is free. After reset
// a clearing pass empties the cell map and refills the free stack, one entry per
// cycle, over max(GRID_SIDE*GRID_SIDE*GRID_HEIGHT, SLOT_COUNT) entries (16384 with
// the defaults); req_tready stays low until it ends.
module chunk_slot_allocator
   import csa_pkg::*;
#(
   parameter int GRID_SIDE   = GRID_SIDE_DEF,
   parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
   parameter int SLOT_COUNT  = SLOT_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // opcode
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // cell_x, cell_y, cell_z, zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // slot_id, present, status, range_low, range_high, range_valid, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int ID_W        = $clog2(SLOT_COUNT);
   localparam int ENTRY_W     = ID_W + 1;
   localparam int CELL_TOTAL  = GRID_SIDE * GRID_SIDE * GRID_HEIGHT;
   localparam int CELL_W      = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
   localparam int SWEEP_TOTAL = (CELL_TOTAL > SLOT_COUNT) ? CELL_TOTAL : SLOT_COUNT;
   localparam int SWEEP_W     = (SWEEP_TOTAL > 1) ? $clog2(SWEEP_TOTAL) : 1;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type          state_ff, state_in;
   logic [SWEEP_W-1:0] sweep_ff;
   logic               sweep_last;
   opcode_type         op_ff;

   logic [ID_W-1:0]    dirty_low_ff, dirty_low_in;
   logic [ID_W-1:0]    dirty_high_ff, dirty_high_in;
   logic               dirty_any_ff, dirty_any_in;

   logic               rsp_valid_ff;
   logic [SLOT_ID_W-1:0] rsp_slot_ff, rsp_low_ff, rsp_high_ff;
   logic               rsp_present_ff, rsp_rvalid_ff;
   status_type         rsp_status_ff;

   logic [ID_W-1:0]    slot_in, range_low_in, range_high_in;
   logic               present_in, range_valid_in;
   status_type         status_in;

   logic               req_accept, exec_done, sweeping;
   cell_ctl_type       cell_ctl;
   stack_ctl_type      stack_ctl;
   logic [ENTRY_W-1:0] cell_wr_data, cell_rd_data;
   logic [ID_W-1:0]    stack_top, push_data;
   logic               stack_empty;
   logic               held;
   logic [ID_W-1:0]    held_id;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign exec_done  = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign sweeping   = (state_ff == S_CLEAR);
   assign sweep_last = (32'(sweep_ff) == SWEEP_TOTAL - 1);

   assign held    = cell_rd_data[ID_W];
   assign held_id = cell_rd_data[ID_W-1:0];

   always_comb begin
      slot_in        = '0;
      present_in     = 1'b0;
      status_in      = STAT_OK;
      range_low_in   = '0;
      range_high_in  = '0;
      range_valid_in = 1'b0;
      dirty_low_in   = dirty_low_ff;
      dirty_high_in  = dirty_high_ff;
      dirty_any_in   = dirty_any_ff;
      cell_wr_data   = '0;
      push_data      = held_id;
      cell_ctl.read  = req_accept;
      cell_ctl.write = 1'b0;
      cell_ctl.clear = sweeping && (32'(sweep_ff) < CELL_TOTAL);
      stack_ctl.read  = req_accept;
      stack_ctl.pop   = 1'b0;
      stack_ctl.push  = 1'b0;
      stack_ctl.clear = sweeping && (32'(sweep_ff) < SLOT_COUNT);
      case (op_ff)
         OP_ALLOC: begin
            present_in = held;
            if (stack_empty) begin
               status_in = STAT_NO_SLOT;
            end else begin
               slot_in        = stack_top;
               cell_wr_data   = {1'b1, stack_top};
               cell_ctl.write = exec_done;
               stack_ctl.pop  = exec_done;
               dirty_any_in   = 1'b1;
               if (!dirty_any_ff) begin
                  dirty_low_in  = stack_top;
                  dirty_high_in = stack_top;
               end else begin
                  if (stack_top < dirty_low_ff) dirty_low_in = stack_top;
                  if (stack_top > dirty_high_ff) dirty_high_in = stack_top;
               end
            end
         end
         OP_FREE: begin
            if (!held) begin
               status_in = STAT_EMPTY_CELL;
            end else begin
               present_in     = 1'b1;
               slot_in        = held_id;
               cell_ctl.write = exec_done;
               stack_ctl.push = exec_done;
            end
         end
         OP_QUERY: begin
            if (held) begin
               present_in = 1'b1;
               slot_in    = held_id;
            end
         end
         OP_TAKE: begin
            if (dirty_any_ff) begin
               range_low_in   = dirty_low_ff;
               range_high_in  = dirty_high_ff;
               range_valid_in = 1'b1;
            end
            dirty_low_in  = '0;
            dirty_high_in = '0;
            dirty_any_in  = 1'b0;
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (sweep_last) state_in = S_IDLE;
         S_IDLE:  if (req_accept) state_in = S_EXEC;
         S_EXEC:  if (exec_done) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         sweep_ff      <= '0;
         dirty_low_ff  <= '0;
         dirty_high_ff <= '0;
         dirty_any_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (sweeping && !sweep_last) begin
            sweep_ff <= sweep_ff + SWEEP_W'(1);
         end
         if (req_accept) begin
            op_ff <= opcode_type'(req_tuser);
         end
         if (exec_done) begin
            dirty_low_ff   <= dirty_low_in;
            dirty_high_ff  <= dirty_high_in;
            dirty_any_ff   <= dirty_any_in;
            rsp_valid_ff   <= 1'b1;
            rsp_slot_ff    <= SLOT_ID_W'(slot_in);
            rsp_present_ff <= present_in;
            rsp_status_ff  <= status_in;
            rsp_low_ff     <= SLOT_ID_W'(range_low_in);
            rsp_high_ff    <= SLOT_ID_W'(range_high_in);
            rsp_rvalid_ff  <= range_valid_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   csa_cell_map #(
      .GRID_SIDE   (GRID_SIDE),
      .GRID_HEIGHT (GRID_HEIGHT),
      .ID_W        (ID_W)
   ) u_cell_map (
      .clock      (clock),
      .ctl        (cell_ctl),
      .cell_x     (req_tdata[CELL_X_W-1:0]),
      .cell_y     (req_tdata[CELL_X_W+CELL_Y_W-1:CELL_X_W]),
      .cell_z     (req_tdata[CELL_X_W+CELL_Y_W+CELL_Z_W-1:CELL_X_W+CELL_Y_W]),
      .clear_addr (CELL_W'(sweep_ff)),
      .wr_data    (cell_wr_data),
      .rd_data    (cell_rd_data)
   );

   csa_free_stack #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_free_stack (
      .clock      (clock),
      .reset      (reset),
      .ctl        (stack_ctl),
      .clear_addr (ID_W'(sweep_ff)),
      .push_data  (push_data),
      .top_data   (stack_top),
      .empty      (stack_empty)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_rvalid_ff, rsp_high_ff, rsp_low_ff,
                        rsp_status_ff, rsp_present_ff, rsp_slot_ff};

endmodule

### design/csa_checker.sv
// Port-level assertions for the chunk slot allocator, bound to the top level.
`timescale 1ns / 1ps

module csa_checker
   import csa_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TUSER_W-1:0] req_tuser,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic req_accept;
   assign req_accept = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_accept ##1 (!rsp_tvalid || rsp_tready) |=> rsp_tvalid)
      else $error("response missing one cycle after the read-modify-write");

   a_range_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> rsp_tdata[12:0] == 13'd0)
      else $error("range response carries slot fields");

   a_error_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12:11] != 2'd0 |-> rsp_tdata[9:0] == 10'd0)
      else $error("error response carries a slot id");

   logic unused_in;
   assign unused_in = ^{req_tuser, req_tdata};

endmodule

bind chunk_slot_allocator csa_checker u_csa_checker (.*);
